// ===== sv/plm_pkg.sv =====
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and constants for the piecewise linear map lookup unit.
// ----------------------------------------------------------------------------
package plm_pkg;

    localparam int TableDepth  = 256;
    localparam int AddrW       = 8;
    localparam int CountW      = 9;
    localparam int DataW       = 32;
    localparam int QueueDepth  = 2;

    localparam logic       REQ_LOAD   = 1'b0;
    localparam logic       REQ_SAMPLE = 1'b1;

    localparam logic [1:0] ST_INTERP  = 2'd0;
    localparam logic [1:0] ST_BELOW   = 2'd1;
    localparam logic [1:0] ST_ABOVE   = 2'd2;
    localparam logic [1:0] ST_REPEAT  = 2'd3;

    typedef struct packed {
        logic                    req_type;
        logic [AddrW-1:0]        entry_index;
        logic signed [DataW-1:0] entry_key;
        logic signed [DataW-1:0] entry_value;
        logic signed [DataW-1:0] sample_in;
        logic                    start_of_waveform;
    } in_t;

    typedef struct packed {
        logic signed [DataW-1:0] mapped_value;
        logic [1:0]              range_status;
    } out_t;

    // handshake between the front queue and the back engine
    typedef struct packed {
        logic avail;
        logic is_sample;
    } fq_stat_t;

endpackage

// ===== sv/plm_front.sv =====
// ----------------------------------------------------------------------------
// plm_front
// Accepts input transactions, tags loads and samples, holds them in a short queue.
// ----------------------------------------------------------------------------
module plm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  plm_pkg::in_t  in_data,
    input  logic          pop,
    output plm_pkg::fq_stat_t stat,
    output plm_pkg::in_t  head
);
    import plm_pkg::*;

    in_t        q_reg [QueueDepth];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop_ok;

    assign in_stall = (cnt_reg == 2'(QueueDepth));
    assign push     = in_valid && !in_stall;
    assign pop_ok   = pop && (cnt_reg != 2'd0);

    assign head           = q_reg[rd_ptr_reg];
    assign stat.avail     = (cnt_reg != 2'd0);
    assign stat.is_sample = (q_reg[rd_ptr_reg].req_type == REQ_SAMPLE);

    always_comb
    begin
        wr_ptr_next = push   ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop_ok);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QueueDepth))
        else $error("queue count overflow");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_ok && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("pop did not drain queue");
`endif

endmodule

// ===== sv/plm_back.sv =====
// ----------------------------------------------------------------------------
// plm_back
// Table storage, slope divider, segment walk and interpolation engine.
// ----------------------------------------------------------------------------
module plm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [8:0]    cfg_wdata,
    input  plm_pkg::fq_stat_t stat,
    input  plm_pkg::in_t  head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output plm_pkg::out_t out_data
);
    import plm_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LD_RD   = 4'd1;
    localparam logic [3:0] S_LD_SET  = 4'd2;
    localparam logic [3:0] S_LD_DIV  = 4'd3;
    localparam logic [3:0] S_LD_WR   = 4'd4;
    localparam logic [3:0] S_UP_RD   = 4'd5;
    localparam logic [3:0] S_UP_CMP  = 4'd6;
    localparam logic [3:0] S_DN_RD   = 4'd7;
    localparam logic [3:0] S_DN_CMP  = 4'd8;
    localparam logic [3:0] S_FIN_RD  = 4'd9;
    localparam logic [3:0] S_MUL_LO  = 4'd10;
    localparam logic [3:0] S_MUL_HI  = 4'd11;
    localparam logic [3:0] S_SUM     = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    localparam int DivSteps = 49;

    logic signed [DataW-1:0] key_mem   [TableDepth];
    logic signed [DataW-1:0] val_mem   [TableDepth];
    logic signed [DataW-1:0] slope_mem [TableDepth];
    logic signed [DataW-1:0] key_rd, val_rd, slope_rd;
    logic [AddrW-1:0]        key_ra, val_ra, slope_ra;
    logic                    mem_we;

    logic [3:0]              state_reg, state_next;
    logic [CountW-1:0]       eiu_reg;
    logic [CountW-1:0]       n_eff;
    logic [CountW-1:0]       seg_reg;
    logic [CountW-1:0]       walk_reg;
    logic signed [DataW-1:0] prev_smp_reg, prev_out_reg;
    logic                    have_prev_reg;
    logic                    rep_hit;
    in_t                     item_reg;

    // load path
    logic signed [DataW:0]   dk_w, dv_w;
    logic [DataW:0]          dsr_reg;
    logic [48:0]             dvd_reg, quo_reg;
    logic [DataW:0]          rem_reg;
    logic                    qneg_reg;
    logic [5:0]              div_cnt_reg;
    logic [DataW+1:0]        trial_w;
    logic signed [DataW-1:0] slope_sat_w;

    // sample path
    logic signed [DataW:0]   dx_w;
    logic signed [49:0]      plo_reg;
    logic signed [47:0]      phi_reg;
    logic signed [65:0]      acc_reg;
    logic signed [65:0]      t_w, sum_w;
    logic signed [49:0]      q_w;
    logic signed [DataW-1:0] base_reg, res_val_reg;
    logic [1:0]              res_st_reg;
    logic                    slot_free;

    logic                    out_valid_reg, out_valid_next;
    out_t                    out_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign slot_free = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == S_IDLE) && stat.avail;

    // a sample equal to the last raw one repeats the last output
    assign rep_hit = !head.start_of_waveform && have_prev_reg
                     && (head.sample_in == prev_smp_reg);

    always_comb
    begin
        if (eiu_reg < 9'd2)
            n_eff = 9'd2;
        else if (eiu_reg > 9'(TableDepth))
            n_eff = 9'(TableDepth);
        else
            n_eff = eiu_reg;
    end

    // read address selection
    always_comb
    begin
        key_ra   = walk_reg[AddrW-1:0];
        val_ra   = '0;
        slope_ra = walk_reg[AddrW-1:0];
        mem_we   = (state_reg == S_LD_WR);
        case (state_reg)
            S_LD_RD:
            begin
                key_ra = item_reg.entry_index - 8'd1;
                val_ra = item_reg.entry_index - 8'd1;
            end
            S_DN_RD:
            begin
                key_ra = 8'(walk_reg - 9'd1);
            end
            S_FIN_RD:
            begin
                key_ra = 8'(walk_reg - 9'd1);
                if (walk_reg == 9'd0)
                    val_ra = '0;
                else
                    val_ra = 8'(walk_reg - 9'd1);
            end
            default:
            begin
                key_ra = walk_reg[AddrW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[item_reg.entry_index]   <= item_reg.entry_key;
            val_mem[item_reg.entry_index]   <= item_reg.entry_value;
            slope_mem[item_reg.entry_index] <= div_done_reg ? slope_sat_w : '0;
        end
        key_rd   <= key_mem[key_ra];
        val_rd   <= val_mem[val_ra];
        slope_rd <= slope_mem[slope_ra];
    end

    // divider arithmetic
    assign dk_w    = 33'(item_reg.entry_key) - 33'(key_rd);
    assign dv_w    = 33'(item_reg.entry_value) - 33'(val_rd);
    assign trial_w = {rem_reg, dvd_reg[48]} - {1'b0, dsr_reg};

    always_comb
    begin
        if (!qneg_reg)
            slope_sat_w = (quo_reg > 49'h7FFFFFFF) ? 32'sh7FFFFFFF : quo_reg[31:0];
        else if (quo_reg > 49'h80000000)
            slope_sat_w = 32'sh80000000;
        else
            slope_sat_w = 32'(-quo_reg);
    end

    // interpolation arithmetic
    assign dx_w  = 33'(item_reg.sample_in) - 33'(key_rd);
    assign t_w   = (66'(phi_reg) <<< 17) + acc_reg;
    assign q_w   = 50'(t_w >>> 16);
    assign sum_w = 66'(base_reg) + 66'(q_w);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.avail)
                begin
                    if (!stat.is_sample)
                        state_next = S_LD_RD;
                    else if (rep_hit)
                        state_next = S_OUT;
                    else
                        state_next = S_UP_RD;
                end
            end
            S_LD_RD:
            begin
                state_next = (item_reg.entry_index == 8'd0) ? S_LD_WR : S_LD_SET;
            end
            S_LD_SET:
            begin
                state_next = (dk_w == 33'sd0) ? S_LD_WR : S_LD_DIV;
            end
            S_LD_DIV:
            begin
                if (div_cnt_reg == 6'(DivSteps - 1))
                    state_next = S_LD_WR;
            end
            S_LD_WR:  state_next = S_IDLE;
            S_UP_RD:  state_next = (walk_reg < n_eff) ? S_UP_CMP : S_DN_RD;
            S_UP_CMP: state_next = (item_reg.sample_in > key_rd) ? S_UP_RD : S_DN_RD;
            S_DN_RD:  state_next = (walk_reg != 9'd0) ? S_DN_CMP : S_FIN_RD;
            S_DN_CMP: state_next = (item_reg.sample_in < key_rd) ? S_DN_RD : S_FIN_RD;
            S_FIN_RD: state_next = S_MUL_LO;
            S_MUL_LO:
            begin
                if (walk_reg == 9'd0 || walk_reg == n_eff)
                    state_next = S_OUT;
                else
                    state_next = S_MUL_HI;
            end
            S_MUL_HI: state_next = S_SUM;
            S_SUM:    state_next = S_OUT;
            S_OUT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == S_OUT && slot_free)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg <= head;
                res_val_reg <= prev_out_reg;
                res_st_reg  <= ST_REPEAT;
            end
            S_LD_SET:
            begin
                dsr_reg     <= dk_w[DataW] ? 33'(-dk_w) : dk_w;
                dvd_reg     <= {(dv_w[DataW] ? 33'(-dv_w) : dv_w), 16'd0};
                qneg_reg    <= dv_w[DataW] ^ dk_w[DataW];
                rem_reg     <= '0;
                quo_reg     <= '0;
                div_cnt_reg <= '0;
            end
            S_LD_DIV:
            begin
                dvd_reg     <= {dvd_reg[47:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 6'd1;
                if (!trial_w[DataW+1])
                begin
                    rem_reg <= trial_w[DataW:0];
                    quo_reg <= {quo_reg[47:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DataW-1:0], dvd_reg[48]};
                    quo_reg <= {quo_reg[47:0], 1'b0};
                end
            end
            S_MUL_LO:
            begin
                base_reg <= val_rd;
                plo_reg  <= slope_rd * $signed({1'b0, dx_w[16:0]});
                phi_reg  <= slope_rd * $signed(dx_w[DataW:17]);
                if (walk_reg == 9'd0)
                begin
                    res_val_reg <= val_rd;
                    res_st_reg  <= ST_BELOW;
                end
                else
                begin
                    res_val_reg <= val_rd;
                    res_st_reg  <= ST_ABOVE;
                end
            end
            S_MUL_HI:
            begin
                acc_reg <= 66'(plo_reg) + 66'sd32768;
            end
            S_SUM:
            begin
                res_st_reg <= ST_INTERP;
                if (sum_w > 66'sh7FFFFFFF)
                    res_val_reg <= 32'sh7FFFFFFF;
                else if (sum_w < -66'sh80000000)
                    res_val_reg <= 32'sh80000000;
                else
                    res_val_reg <= sum_w[DataW-1:0];
            end
            default:
            begin
                base_reg <= base_reg;
            end
        endcase
        if (state_reg == S_OUT && slot_free)
            out_reg <= '{mapped_value: res_val_reg, range_status: res_st_reg};
    end

    // high in the write cycle of a load whose slope came from the divider
    logic div_done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_done_reg <= 1'b0;
        else
            div_done_reg <= (state_reg == S_LD_DIV) && (state_next == S_LD_WR);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            eiu_reg       <= 9'd2;
            seg_reg       <= 9'd1;
            walk_reg      <= 9'd1;
            prev_smp_reg  <= '0;
            prev_out_reg  <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                eiu_reg <= cfg_wdata;
            case (state_reg)
                S_IDLE:
                begin
                    if (stat.avail && stat.is_sample)
                    begin
                        if (head.start_of_waveform)
                        begin
                            have_prev_reg <= 1'b0;
                            seg_reg       <= 9'd1;
                            walk_reg      <= 9'd1;
                        end
                        else if (seg_reg >= n_eff)
                            walk_reg <= n_eff - 9'd1;
                        else
                            walk_reg <= seg_reg;
                    end
                end
                S_UP_CMP:
                begin
                    if (item_reg.sample_in > key_rd)
                        walk_reg <= walk_reg + 9'd1;
                end
                S_DN_CMP:
                begin
                    if (item_reg.sample_in < key_rd)
                        walk_reg <= walk_reg - 9'd1;
                end
                S_MUL_LO:
                begin
                    if (walk_reg == 9'd0)
                        walk_reg <= 9'd1;
                    else if (walk_reg == n_eff)
                        walk_reg <= n_eff - 9'd1;
                end
                S_OUT:
                begin
                    if (slot_free)
                    begin
                        if (res_st_reg != ST_REPEAT)
                        begin
                            seg_reg       <= walk_reg;
                            prev_smp_reg  <= item_reg.sample_in;
                            prev_out_reg  <= res_val_reg;
                            have_prev_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    have_prev_reg <= have_prev_reg;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (seg_reg != 9'd0))
        else $error("segment index fell to zero");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN_RD) |-> (walk_reg <= n_eff))
        else $error("walk index beyond entry count");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LD_DIV) |-> (div_cnt_reg < 6'(DivSteps)))
        else $error("divider ran past its steps");
`endif

endmodule

// ===== sv/piecewise_linear_map_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_map_lookup_unit
// Maps signed Q16.16 samples through a loaded key/value table by interpolation.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid/in_stall with in_data; req_type picks a table load
//     or a sample lookup; loads produce no output transaction
//   out channel: out_valid/out_stall with out_data, one transaction per sample
//   cfg_we/cfg_wdata write the entry count; the user must do so only
//   while the unit is idle, as the block itself does not enforce it
// sequencing
//   a repeated sample goes straight to the output; any other sample walks
//   from the kept segment index, one registered table read per compare, then
//   is clamped or interpolated; the next item starts once the previous one
//   has left the engine; a load skips the slope divider at slot zero and
//   for equal keys, else runs the one-bit-a-cycle slope divider
// reset
//   queue empty, entry count 2, segment index 1, repeat memory cleared;
//   table contents are undefined until loaded
// stall
//   a finished result waits in the output register while the next item is
//   worked on; the two-entry input queue raises in_stall once it is full
// ----------------------------------------------------------------------------
module piecewise_linear_map_lookup_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  plm_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output plm_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [8:0]    cfg_wdata
);
    import plm_pkg::*;

    // queue status and head item toward the engine
    fq_stat_t stat;
    in_t      head;
    logic     pop;

    plm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .pop      (pop),
        .stat     (stat),
        .head     (head)
    );

    // table, divider, segment walk and interpolation
    plm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
